FILE: rtl/ogsf_pkg.sv
// ----------------------------------------------------------------------------
// Static occupancy-grid fusion package
// Shared sizes, register indexes, request codes, cell values and the controller command.
// ----------------------------------------------------------------------------
package ogsf_pkg;

    // Grid geometry and sub-sampling.
    localparam int MAP_WIDTH    = 256;
    localparam int MAP_HEIGHT   = 256;
    localparam int SAMPLES      = 4;
    localparam int LOCAL_WIDTH  = 1024;
    localparam int LOCAL_HEIGHT = 1024;

    // Field widths.
    localparam int ADDR_W  = 16;
    localparam int VAL_W   = 8;
    localparam int CELL_W  = 10;
    localparam int CFG_W   = 32;
    localparam int THR_W   = 7;
    localparam int CIDX_W  = 3;
    localparam int STORE_DEPTH = 1 << ADDR_W;

    // Sample counter width and the widths of the fixed-point positions.
    localparam int SAMP_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int IDX_W  = CELL_W + SAMP_W;
    localparam int PROD_W = IDX_W + 1 + CFG_W;
    localparam int POS_W  = PROD_W + 2;
    localparam int FRAC_W = 16;
    localparam int CRD_W  = 13;

    // Request codes.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_FUSE = 1'b1;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_STEP_COL_X = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_STEP_COL_Y = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_STEP_ROW_X = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_STEP_ROW_Y = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_START_X    = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_START_Y    = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_STATIC_THR = 3'd6;
    localparam logic [CIDX_W-1:0] CFG_LOCAL_THR  = 3'd7;

    // Cell values.
    localparam logic signed [VAL_W-1:0] VAL_OCCUPIED = 8'sd100;
    localparam logic signed [VAL_W-1:0] VAL_UNKNOWN  = -8'sd1;
    localparam logic signed [VAL_W-1:0] VAL_FREE     = 8'sd0;
    localparam logic [THR_W-1:0]        THR_MAX      = 7'd100;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_wr;
        logic capture;
        logic base_en;
        logic col_step;
        logic row_step;
        logic sample_rd;
        logic finish;
    } ogsf_cmd_t;

endpackage

FILE: rtl/occupancy_grid_static_fusion.sv
// ----------------------------------------------------------------------------
// Static occupancy-grid fusion
// Loads a static map cell by cell and fuses local cells against it.
// ----------------------------------------------------------------------------
// A load request (req_type 0) writes one map cell in the cycle it is accepted
// and returns nothing. A fuse request (req_type 1) holds busy high through its
// sum, walk, drain and finish states and then shows cell_value for exactly
// one cycle with done high; that beat cannot be held off, so the receiver
// must take it then. The walk issues one read per cycle on the single read
// port of the map store, which sets how long busy stays high. The user must
// ensure that configuration is written only while busy is low and no result
// is pending; the block does not enforce this. cfg_ready is always high.
module occupancy_grid_static_fusion (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                req_type,
    input  logic [ogsf_pkg::ADDR_W-1:0]         map_addr,
    input  logic signed [ogsf_pkg::VAL_W-1:0]   map_value,
    input  logic [ogsf_pkg::CELL_W-1:0]         cell_x,
    input  logic [ogsf_pkg::CELL_W-1:0]         cell_y,
    input  logic signed [ogsf_pkg::VAL_W-1:0]   grid_value,
    output logic                                done,
    output logic signed [ogsf_pkg::VAL_W-1:0]   cell_value,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ogsf_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [ogsf_pkg::CFG_W-1:0]          cfg_data
);
    import ogsf_pkg::*;

    ogsf_cmd_t cmd;

    // Configuration beats are always taken.
    assign cfg_ready = 1'b1;

    // Controller.
    ogsf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .busy     (busy),
        .done     (done),
        .cmd      (cmd)
    );

    // Datapath.
    ogsf_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .map_addr    (map_addr),
        .map_value   (map_value),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .grid_value  (grid_value),
        .cell_value  (cell_value)
    );

endmodule

FILE: rtl/ogsf_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ogsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/ogsf_ctrl.sv
// ----------------------------------------------------------------------------
// Static occupancy-grid fusion controller
// Sequences the base computation, the sample walk and the result beat.
// ----------------------------------------------------------------------------
module ogsf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               req_type,
    output logic               busy,
    output logic               done,
    output ogsf_pkg::ogsf_cmd_t cmd
);
    import ogsf_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SUM   = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    localparam logic [SAMP_W-1:0] SAMP_LAST = SAMP_W'(SAMPLES - 1);

    logic [2:0]        state_reg, state_next;
    logic [SAMP_W-1:0] sx_reg, sx_next;
    logic [SAMP_W-1:0] sy_reg, sy_next;
    logic              done_reg, done_next;

    // State and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sx_reg    <= '0;
            sy_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            done_reg  <= done_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req_type == REQ_FUSE)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_SUM;
                    end
                    else
                    begin
                        cmd.load_wr = 1'b1;
                    end
                end
            end
            ST_SUM:
            begin
                cmd.base_en = 1'b1;
                sx_next     = '0;
                sy_next     = '0;
                state_next  = ST_WALK;
            end
            ST_WALK:
            begin
                cmd.sample_rd = 1'b1;
                if (sx_reg == SAMP_LAST)
                begin
                    if (sy_reg == SAMP_LAST)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        cmd.row_step = 1'b1;
                        sx_next      = '0;
                        sy_next      = sy_reg + 1'b1;
                    end
                end
                else
                begin
                    cmd.col_step = 1'b1;
                    sx_next      = sx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

FILE: rtl/ogsf_dp.sv
// ----------------------------------------------------------------------------
// Static occupancy-grid fusion datapath
// Configuration registers, sample position walk, map store and merge logic.
// ----------------------------------------------------------------------------
module ogsf_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ogsf_pkg::ogsf_cmd_t                 cmd,
    input  logic                                cfg_we,
    input  logic [ogsf_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [ogsf_pkg::CFG_W-1:0]          cfg_data,
    input  logic [ogsf_pkg::ADDR_W-1:0]         map_addr,
    input  logic signed [ogsf_pkg::VAL_W-1:0]   map_value,
    input  logic [ogsf_pkg::CELL_W-1:0]         cell_x,
    input  logic [ogsf_pkg::CELL_W-1:0]         cell_y,
    input  logic signed [ogsf_pkg::VAL_W-1:0]   grid_value,
    output logic signed [ogsf_pkg::VAL_W-1:0]   cell_value
);
    import ogsf_pkg::*;

    // Configuration registers.
    logic signed [CFG_W-1:0] step_col_x_reg, step_col_y_reg;
    logic signed [CFG_W-1:0] step_row_x_reg, step_row_y_reg;
    logic signed [CFG_W-1:0] start_x_reg, start_y_reg;
    logic [THR_W-1:0]        static_thr_reg, local_thr_reg;

    // Per-cell registers.
    logic signed [PROD_W-1:0] prod_cx_reg, prod_cy_reg, prod_rx_reg, prod_ry_reg;
    logic signed [VAL_W-1:0]  local_reg;
    logic                     cell_oob_reg;
    logic signed [POS_W-1:0]  row_x_reg, row_y_reg, cur_x_reg, cur_y_reg;
    logic                     rd_pend_reg, inb_reg;
    logic                     occ_reg, unk_reg;
    logic signed [VAL_W-1:0]  cell_value_reg;

    logic [IDX_W-1:0]         i0, j0;
    logic signed [POS_W-1:0]  base_x, base_y, row_x_step, row_y_step;
    logic signed [POS_W-FRAC_W-1:0] ix, iy;
    logic                     inbound;
    logic [CRD_W-1:0]         ix_u, iy_u;
    logic [ADDR_W-1:0]        rd_addr;
    logic [VAL_W-1:0]         rd_data;
    logic signed [VAL_W-1:0]  sample_v;
    logic [THR_W-1:0]         sthr, lthr;
    logic signed [VAL_W-1:0]  result;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_col_x_reg <= 32'sd65536;
            step_col_y_reg <= '0;
            step_row_x_reg <= '0;
            step_row_y_reg <= 32'sd65536;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            static_thr_reg <= THR_MAX;
            local_thr_reg  <= THR_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STEP_COL_X: step_col_x_reg <= cfg_data;
                CFG_STEP_COL_Y: step_col_y_reg <= cfg_data;
                CFG_STEP_ROW_X: step_row_x_reg <= cfg_data;
                CFG_STEP_ROW_Y: step_row_y_reg <= cfg_data;
                CFG_START_X:    start_x_reg    <= cfg_data;
                CFG_START_Y:    start_y_reg    <= cfg_data;
                CFG_STATIC_THR: static_thr_reg <= cfg_data[THR_W-1:0];
                CFG_LOCAL_THR:  local_thr_reg  <= cfg_data[THR_W-1:0];
                default:        ;
            endcase
        end
    end

    // First sub-sample index of the cell along each local axis.
    assign i0 = IDX_W'(32'(cell_x) * SAMPLES);
    assign j0 = IDX_W'(32'(cell_y) * SAMPLES);

    // Capture the cell and form the four offset products.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            prod_cx_reg  <= $signed({1'b0, i0}) * step_col_x_reg;
            prod_cy_reg  <= $signed({1'b0, i0}) * step_col_y_reg;
            prod_rx_reg  <= $signed({1'b0, j0}) * step_row_x_reg;
            prod_ry_reg  <= $signed({1'b0, j0}) * step_row_y_reg;
            local_reg    <= grid_value;
            cell_oob_reg <= (32'(cell_x) >= LOCAL_WIDTH) || (32'(cell_y) >= LOCAL_HEIGHT);
        end
    end

    // Position of the first sample and of the next row.
    assign base_x = POS_W'(start_x_reg) + POS_W'(prod_cx_reg) + POS_W'(prod_rx_reg);
    assign base_y = POS_W'(start_y_reg) + POS_W'(prod_cy_reg) + POS_W'(prod_ry_reg);
    assign row_x_step = row_x_reg + POS_W'(step_row_x_reg);
    assign row_y_step = row_y_reg + POS_W'(step_row_y_reg);

    // Sample position walk.
    always_ff @(posedge clk)
    begin
        if (cmd.base_en)
        begin
            row_x_reg <= base_x;
            row_y_reg <= base_y;
            cur_x_reg <= base_x;
            cur_y_reg <= base_y;
        end
        else if (cmd.row_step)
        begin
            row_x_reg <= row_x_step;
            row_y_reg <= row_y_step;
            cur_x_reg <= row_x_step;
            cur_y_reg <= row_y_step;
        end
        else if (cmd.col_step)
        begin
            cur_x_reg <= cur_x_reg + POS_W'(step_col_x_reg);
            cur_y_reg <= cur_y_reg + POS_W'(step_col_y_reg);
        end
    end

    // Floor to a map cell, bounds check and address.
    assign ix      = cur_x_reg[POS_W-1:FRAC_W];
    assign iy      = cur_y_reg[POS_W-1:FRAC_W];
    assign inbound = (ix >= 0) && (iy >= 0) && (ix < MAP_WIDTH) && (iy < MAP_HEIGHT);
    assign ix_u    = ix[CRD_W-1:0];
    assign iy_u    = iy[CRD_W-1:0];
    assign rd_addr = ADDR_W'(32'(iy_u) * MAP_WIDTH + 32'(ix_u));

    // Static map store.
    ogsf_ram #(
        .WIDTH (VAL_W),
        .DEPTH (STORE_DEPTH)
    ) u_map (
        .clk     (clk),
        .wr_en   (cmd.load_wr),
        .wr_addr (map_addr),
        .wr_data (map_value),
        .rd_en   (cmd.sample_rd),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign sample_v = rd_data;
    assign sthr = (static_thr_reg > THR_MAX) ? THR_MAX : static_thr_reg;
    assign lthr = (local_thr_reg > THR_MAX) ? THR_MAX : local_thr_reg;

    // Accumulate the occupied and unknown flags as read data returns.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg <= 1'b0;
            inb_reg     <= 1'b0;
            occ_reg     <= 1'b0;
            unk_reg     <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.sample_rd;
            inb_reg     <= inbound;
            if (cmd.base_en)
            begin
                occ_reg <= 1'b0;
                unk_reg <= 1'b0;
            end
            else if (rd_pend_reg)
            begin
                if (!inb_reg)
                begin
                    unk_reg <= 1'b1;
                end
                else
                begin
                    if (sample_v < 0)
                    begin
                        unk_reg <= 1'b1;
                    end
                    if (sample_v >= $signed({1'b0, sthr}))
                    begin
                        occ_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // Merge with the local value.
    always_comb
    begin
        if (cell_oob_reg)
        begin
            result = VAL_UNKNOWN;
        end
        else if (occ_reg)
        begin
            result = VAL_OCCUPIED;
        end
        else if (unk_reg)
        begin
            result = VAL_UNKNOWN;
        end
        else if (local_reg >= $signed({1'b0, lthr}))
        begin
            result = VAL_OCCUPIED;
        end
        else if (local_reg >= 0)
        begin
            result = local_reg;
        end
        else
        begin
            result = VAL_FREE;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            cell_value_reg <= result;
        end
    end

    assign cell_value = cell_value_reg;

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Static occupancy-grid fusion testbench
// Drives map loads and fuse requests through the start/busy port, mirrors the
// map store and the geometry registers, and predicts every fused value. Each
// done beat is compared against the oldest prediction. Directed tests cover
// the merge rules, threshold clamping and out-of-map samples; random traffic
// then sweeps several geometries under three idling profiles.
// ----------------------------------------------------------------------------
module tb_top;
    import ogsf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_GAP        = 24;
    localparam int BEATS_PER_GEOM = 50;

    // The single static map cell that every sample hits in the point geometry.
    localparam int POINT_COL  = 3;
    localparam int POINT_ROW  = 7;
    localparam logic [ADDR_W-1:0] POINT_ADDR = ADDR_W'(POINT_ROW * MAP_WIDTH + POINT_COL);

    // One request beat, every field as driven on the ports.
    typedef struct packed {
        logic                      req;
        logic [ADDR_W-1:0]         addr;
        logic signed [VAL_W-1:0]   mval;
        logic [CELL_W-1:0]         cx;
        logic [CELL_W-1:0]         cy;
        logic signed [VAL_W-1:0]   lval;
    } grid_req_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic                        req_type = REQ_LOAD;
    logic [ADDR_W-1:0]           map_addr = '0;
    logic signed [VAL_W-1:0]     map_value = '0;
    logic [CELL_W-1:0]           cell_x = '0;
    logic [CELL_W-1:0]           cell_y = '0;
    logic signed [VAL_W-1:0]     grid_value = '0;
    logic                        done;
    logic signed [VAL_W-1:0]     cell_value;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CIDX_W-1:0]           cfg_index = '0;
    logic [CFG_W-1:0]            cfg_data = '0;

    // Mirror of the map store and of the configuration registers.
    logic signed [VAL_W-1:0]     map_mirror [STORE_DEPTH];
    bit                          map_written [STORE_DEPTH];
    logic signed [CFG_W-1:0]     geo_step_col_x = 32'sh0001_0000;
    logic signed [CFG_W-1:0]     geo_step_col_y = '0;
    logic signed [CFG_W-1:0]     geo_step_row_x = '0;
    logic signed [CFG_W-1:0]     geo_step_row_y = 32'sh0001_0000;
    logic signed [CFG_W-1:0]     geo_start_x = '0;
    logic signed [CFG_W-1:0]     geo_start_y = '0;
    logic [THR_W-1:0]            static_thr = THR_MAX;
    logic [THR_W-1:0]            local_thr = THR_MAX;

    // Fused values still owed by the block, oldest first.
    logic signed [VAL_W-1:0]     fused_q [$];

    int                          error_count = 0;
    int                          beats_sent = 0;
    int                          send_idle_pct = 15;
    int                          idle_cycles = 0;

    always #6 clk = ~clk;

    occupancy_grid_static_fusion u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .map_addr    (map_addr),
        .map_value   (map_value),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .grid_value  (grid_value),
        .done        (done),
        .cell_value  (cell_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Map cell hit by sub-sample (sx, sy) of local cell (cx, cy).
    function automatic void sample_addr(input logic [CELL_W-1:0] cx,
                                        input logic [CELL_W-1:0] cy,
                                        input int sx,
                                        input int sy,
                                        output bit in_map,
                                        output logic [ADDR_W-1:0] addr);
        longint col_idx, row_idx, px, py, ix, iy;
        col_idx = longint'(cx) * SAMPLES + sx;
        row_idx = longint'(cy) * SAMPLES + sy;
        px = longint'(geo_start_x) + col_idx * longint'(geo_step_col_x)
             + row_idx * longint'(geo_step_row_x);
        py = longint'(geo_start_y) + col_idx * longint'(geo_step_col_y)
             + row_idx * longint'(geo_step_row_y);
        // An arithmetic shift floors toward minus infinity.
        ix = px >>> FRAC_W;
        iy = py >>> FRAC_W;
        in_map = (ix >= 0) && (iy >= 0) && (ix < MAP_WIDTH) && (iy < MAP_HEIGHT);
        addr = ADDR_W'(iy * MAP_WIDTH + ix);
    endfunction

    // Fused value of one local cell against the mirrored map.
    function automatic logic signed [VAL_W-1:0] fused_value(
            input logic [CELL_W-1:0] cx,
            input logic [CELL_W-1:0] cy,
            input logic signed [VAL_W-1:0] lval);
        int sthr, lthr, v;
        bit occ, unk, in_map;
        logic [ADDR_W-1:0] addr;
        sthr = (static_thr > THR_MAX) ? int'(THR_MAX) : int'(static_thr);
        lthr = (local_thr > THR_MAX) ? int'(THR_MAX) : int'(local_thr);
        occ = 1'b0;
        unk = 1'b0;
        if (cx >= LOCAL_WIDTH || cy >= LOCAL_HEIGHT)
            return VAL_UNKNOWN;
        for (int sy = 0; sy < SAMPLES; sy++)
        begin
            for (int sx = 0; sx < SAMPLES; sx++)
            begin
                sample_addr(cx, cy, sx, sy, in_map, addr);
                if (!in_map)
                begin
                    unk = 1'b1;
                end
                else
                begin
                    v = map_mirror[addr];
                    if (v < 0)
                        unk = 1'b1;
                    if (v >= sthr)
                        occ = 1'b1;
                end
            end
        end
        if (occ)
            return VAL_OCCUPIED;
        if (unk)
            return VAL_UNKNOWN;
        if (int'(lval) >= lthr)
            return VAL_OCCUPIED;
        if (lval >= 0)
            return lval;
        return VAL_FREE;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking and watchdog
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what,
                                   input logic signed [VAL_W-1:0] want,
                                   input logic signed [VAL_W-1:0] got);
        $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $time);
        error_count++;
    endtask

    // Each done beat is taken against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        logic signed [VAL_W-1:0] want;
        if (rst_n && done)
        begin
            if (fused_q.size() == 0)
            begin
                report_mismatch("result with nothing expected", VAL_UNKNOWN, cell_value);
            end
            else
            begin
                want = fused_q.pop_front();
                if (cell_value !== want)
                    report_mismatch("cell_value", want, cell_value);
            end
        end
    end

    // End the run when nothing has been accepted for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Request and register drivers
    // ------------------------------------------------------------------------

    function automatic grid_req_t make_load(input logic [ADDR_W-1:0] addr,
                                            input logic signed [VAL_W-1:0] val);
        grid_req_t b;
        b.req  = REQ_LOAD;
        b.addr = addr;
        b.mval = val;
        b.cx   = CELL_W'($urandom);
        b.cy   = CELL_W'($urandom);
        b.lval = VAL_W'($urandom);
        return b;
    endfunction

    function automatic grid_req_t make_fuse(input logic [CELL_W-1:0] cx,
                                            input logic [CELL_W-1:0] cy,
                                            input logic signed [VAL_W-1:0] lval);
        grid_req_t b;
        b.req  = REQ_FUSE;
        b.addr = ADDR_W'($urandom);
        b.mval = VAL_W'($urandom);
        b.cx   = cx;
        b.cy   = cy;
        b.lval = lval;
        return b;
    endfunction

    // Send one beat, with an optional idle gap in front, and predict on accept.
    task automatic send_beat(input grid_req_t beat);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, MAX_GAP) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start       <= 1'b1;
        req_type    <= beat.req;
        map_addr    <= beat.addr;
        map_value   <= beat.mval;
        cell_x      <= beat.cx;
        cell_y      <= beat.cy;
        grid_value  <= beat.lval;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        beats_sent++;
        if (beat.req == REQ_LOAD)
        begin
            map_mirror[beat.addr]  = beat.mval;
            map_written[beat.addr] = 1'b1;
        end
        else
        begin
            fused_q.push_back(fused_value(beat.cx, beat.cy, beat.lval));
        end
    endtask

    // Biased toward free cells so that the local value often gets through.
    function automatic logic signed [VAL_W-1:0] rand_map_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 90)
            return VAL_W'($urandom_range(0, 60));
        if (roll < 95)
            return VAL_W'($urandom_range(128, 255));
        return VAL_W'($urandom_range(61, 127));
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_local_value();
        int roll;
        roll = $urandom_range(9);
        if (roll < 6)
            return VAL_W'($urandom_range(0, 100));
        if (roll < 8)
            return VAL_W'($urandom);
        if (roll < 9)
            return VAL_W'($urandom_range(101, 127));
        return VAL_W'($urandom_range(128, 255));
    endfunction

    // Load every map cell that the fuse will read and that is still unwritten, then send the fuse.
    task automatic fuse_request(input logic [CELL_W-1:0] cx,
                                input logic [CELL_W-1:0] cy,
                                input logic signed [VAL_W-1:0] lval);
        bit in_map;
        logic [ADDR_W-1:0] addr;
        for (int sy = 0; sy < SAMPLES; sy++)
        begin
            for (int sx = 0; sx < SAMPLES; sx++)
            begin
                sample_addr(cx, cy, sx, sy, in_map, addr);
                if (in_map && !map_written[addr])
                    send_beat(make_load(addr, rand_map_value()));
            end
        end
        send_beat(make_fuse(cx, cy, lval));
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_STEP_COL_X: geo_step_col_x = data;
            CFG_STEP_COL_Y: geo_step_col_y = data;
            CFG_STEP_ROW_X: geo_step_row_x = data;
            CFG_STEP_ROW_Y: geo_step_row_y = data;
            CFG_START_X:    geo_start_x = data;
            CFG_START_Y:    geo_start_y = data;
            CFG_STATIC_THR: static_thr = data[THR_W-1:0];
            CFG_LOCAL_THR:  local_thr = data[THR_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait for the block to drain before touching its registers.
    task automatic settle_block();
        @(negedge clk);
        start <= 1'b0;
        while (fused_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] scx, input logic [CFG_W-1:0] scy,
                                input logic [CFG_W-1:0] srx, input logic [CFG_W-1:0] sry,
                                input logic [CFG_W-1:0] x0, input logic [CFG_W-1:0] y0,
                                input logic [THR_W-1:0] sthr, input logic [THR_W-1:0] lthr);
        settle_block();
        write_reg(CFG_STEP_COL_X, scx);
        write_reg(CFG_STEP_COL_Y, scy);
        write_reg(CFG_STEP_ROW_X, srx);
        write_reg(CFG_STEP_ROW_Y, sry);
        write_reg(CFG_START_X, x0);
        write_reg(CFG_START_Y, y0);
        write_reg(CFG_STATIC_THR, CFG_W'(sthr));
        write_reg(CFG_LOCAL_THR, CFG_W'(lthr));
    endtask

    // Zero steps: all sixteen samples land on the one map cell under the start.
    task automatic point_geometry(input logic [CFG_W-1:0] x0, input logic [CFG_W-1:0] y0,
                                  input logic [THR_W-1:0] sthr,
                                  input logic [THR_W-1:0] lthr);
        set_geometry('0, '0, '0, '0, x0, y0, sthr, lthr);
    endtask

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Free map cell: the local value decides.
    task automatic test_local_merge();
        point_geometry({16'(POINT_COL), 16'h8000}, {16'(POINT_ROW), 16'hFFFF},
                       THR_MAX, THR_MAX);
        send_beat(make_load(POINT_ADDR, VAL_FREE));
        fuse_request('0, '0, 8'sd0);
        fuse_request(10'd1023, 10'd1023, 8'sd55);
        fuse_request(10'd1023, '0, 8'sd100);
        fuse_request('0, 10'd1023, 8'sd127);
        fuse_request(10'd512, 10'd256, -8'sd1);
        fuse_request(10'd341, 10'd682, -8'sd128);
    endtask

    // Static value just below, at and above the threshold, and unknown.
    task automatic test_static_samples();
        logic signed [VAL_W-1:0] values [5] = '{8'sd99, 8'sd100, 8'sd127, -8'sd1, -8'sd128};
        point_geometry({16'(POINT_COL), 16'h0000}, {16'(POINT_ROW), 16'h8000},
                       THR_MAX, THR_MAX);
        send_beat(make_load('0, 8'sd127));
        send_beat(make_load('1, -8'sd128));
        foreach (values[k])
        begin
            send_beat(make_load(POINT_ADDR, values[k]));
            fuse_request(CELL_W'(k), CELL_W'(k), 8'sd42);
        end
    endtask

    // Thresholds above 100 act as 100; zero thresholds mark every non-negative value occupied.
    task automatic test_threshold_clamp();
        point_geometry({16'(POINT_COL), 16'h0001}, {16'(POINT_ROW), 16'h0000},
                       7'd127, 7'd127);
        send_beat(make_load(POINT_ADDR, 8'sd100));
        fuse_request(10'd7, 10'd9, 8'sd0);
        send_beat(make_load(POINT_ADDR, VAL_FREE));
        fuse_request(10'd7, 10'd9, 8'sd100);
        fuse_request(10'd7, 10'd9, 8'sd99);
        point_geometry({16'(POINT_COL), 16'h0000}, {16'(POINT_ROW), 16'h0000}, '0, '0);
        fuse_request(10'd7, 10'd9, 8'sd0);
    endtask

    // Samples that fall off every edge of the map.
    task automatic test_out_of_map();
        point_geometry(32'hFFFF_FFFF, '0, THR_MAX, THR_MAX);
        fuse_request(10'd5, 10'd5, 8'sd50);
        point_geometry(32'(MAP_WIDTH) << FRAC_W, '0, THR_MAX, THR_MAX);
        fuse_request(10'd5, 10'd5, 8'sd50);
        point_geometry(32'h7FFF_FFFF, 32'h8000_0000, THR_MAX, THR_MAX);
        fuse_request(10'd5, 10'd5, 8'sd50);
        set_geometry(32'h0001_0000, '0, '0, 32'h0001_0000, '0, '0, THR_MAX, THR_MAX);
        fuse_request(10'd64, '0, 8'sd50);
        fuse_request(10'd1023, 10'd1023, 8'sd50);
    endtask

    // ------------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------------

    function automatic logic [CFG_W-1:0] extreme_word();
        case ($urandom_range(3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [THR_W-1:0] rand_threshold();
        case ($urandom_range(4))
            0: return '0;
            1: return THR_MAX;
            2: return 7'd127;
            default: return THR_W'($urandom_range(61, 100));
        endcase
    endfunction

    // Small signed skew of up to 1/64 cell per sub-sample.
    function automatic logic [CFG_W-1:0] small_skew();
        return 32'($urandom_range(0, 32'h800) - 32'h400);
    endfunction

    // Mostly cells near the origin of the chosen window, some anywhere.
    function automatic logic [CELL_W-1:0] pick_coord(input int window);
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return CELL_W'($urandom_range(0, window));
        if (roll < 85)
            return CELL_W'($urandom);
        return (roll % 2 != 0) ? '0 : '1;
    endfunction

    // Identity, fine, mirrored and extreme geometries.
    task automatic random_geometry(input int kind, output int window);
        case (kind)
            0:
            begin
                set_geometry(32'h0001_0000, '0, '0, 32'h0001_0000,
                             32'($urandom_range(0, 32'h1FFFF)),
                             32'($urandom_range(0, 32'h1FFFF)),
                             rand_threshold(), rand_threshold());
                window = 3;
            end
            1:
            begin
                set_geometry(32'($urandom_range(32'h800, 32'h1000)), small_skew(),
                             small_skew(), 32'($urandom_range(32'h800, 32'h1000)),
                             {16'($urandom_range(4, 200)), 16'($urandom)},
                             {16'($urandom_range(4, 200)), 16'($urandom)},
                             rand_threshold(), rand_threshold());
                window = 63;
            end
            2:
            begin
                set_geometry(32'(0 - $urandom_range(32'h800, 32'h1000)), small_skew(),
                             small_skew(), 32'(0 - $urandom_range(32'h800, 32'h1000)),
                             {16'($urandom_range(200, 255)), 16'($urandom)},
                             {16'($urandom_range(200, 255)), 16'($urandom)},
                             rand_threshold(), rand_threshold());
                window = 63;
            end
            default:
            begin
                set_geometry(extreme_word(), extreme_word(), extreme_word(),
                             extreme_word(), extreme_word(), extreme_word(),
                             rand_threshold(), THR_W'($urandom));
                window = 1023;
            end
        endcase
    endtask

    // One idling profile across every kind of geometry.
    task automatic test_random_traffic(input int idle_pct);
        int window;
        int goal;
        send_idle_pct = idle_pct;
        for (int kind = 0; kind < 4; kind++)
        begin
            random_geometry(kind, window);
            goal = beats_sent + BEATS_PER_GEOM;
            while (beats_sent < goal)
            begin
                if ($urandom_range(99) < 12)
                    send_beat(make_load(ADDR_W'($urandom), VAL_W'($urandom)));
                else
                    fuse_request(pick_coord(window), pick_coord(window), rand_local_value());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    initial
    begin
        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;
        test_local_merge();
        test_static_samples();
        test_threshold_clamp();
        test_out_of_map();
        test_random_traffic(15);
        test_random_traffic(77);
        test_random_traffic(0);
        @(negedge clk);
        start <= 1'b0;
        while (fused_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: occupancy_grid_static_fusion.f
rtl/ogsf_pkg.sv
rtl/ogsf_ram.sv
rtl/ogsf_ctrl.sv
rtl/ogsf_dp.sv
rtl/occupancy_grid_static_fusion.sv
tb/tb_top.sv
